### sv/lcd_scanline_mode_timer_defines.svh
// ---------------------------------------------------------------------------
// LCD scanline mode timer: assertion macros
// Shared concurrent assertion forms used by the timer RTL.
// ---------------------------------------------------------------------------
`ifndef LCD_SCANLINE_MODE_TIMER_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LSMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsmt: implication check failed");

// next-cycle implication, disabled during reset
`define LSMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsmt: next-cycle check failed");

`endif

### sv/lsmt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD scanline mode timer package
// Request opcodes, display mode codes and timing constants.
// ---------------------------------------------------------------------------
package lsmt_pkg;

    typedef enum logic [2:0] {
        OP_ADVANCE   = 3'd0,
        OP_WR_CTRL   = 3'd1,
        OP_WR_STATUS = 3'd2,
        OP_CLR_LINE  = 3'd3,
        OP_WR_CMP    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MD_HBLANK   = 2'd0,
        MD_VBLANK   = 2'd1,
        MD_OAM      = 2'd2,
        MD_TRANSFER = 2'd3
    } t_lcd_mode;

    localparam logic [9:0] CYC_VBLANK_LINE = 10'd456;
    localparam logic [9:0] CYC_HBLANK      = 10'd204;
    localparam logic [9:0] CYC_OAM         = 10'd80;
    localparam logic [9:0] CYC_TRANSFER    = 10'd172;

    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_WRAP   = 8'd154;
    localparam logic [7:0] LINE_OFF    = 8'd153;

    localparam logic [7:0] STAT_WMASK  = 8'hF8;

    // status bit positions
    localparam int unsigned ST_COINC    = 2;
    localparam int unsigned ST_HBL_EN   = 3;
    localparam int unsigned ST_VBL_EN   = 4;
    localparam int unsigned ST_OAM_EN   = 5;
    localparam int unsigned ST_COINC_EN = 6;

endpackage

### sv/lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps
// Result: registered; a request's result is loaded at the clock edge that accepts it.
// Throughput: one request per cycle while results are taken; a request is taken when
//   the result register is empty or is drained in that same cycle, so a stalled
//   result holds off the next request until it is taken.
// Reset: synchronous, active low; display off, line 153, VBlank mode, clock 456.
// ---------------------------------------------------------------------------
// LCD scanline mode timer
// Steps an LCD controller through OAM / transfer / HBlank / VBlank line
// timing, one advance-or-register-write request at a time, and reports the
// line, status byte and interrupt / event flags for every request.
// ---------------------------------------------------------------------------
module lcd_scanline_mode_timer
    import lsmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_mode,
    input  logic [6:0] i_cycles,
    input  logic [7:0] i_value,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_line,
    output logic [7:0] o_status,
    output logic       o_vblank_irq,
    output logic       o_stat_irq,
    output logic       o_line_ready,
    output logic       o_frame_done
);

`include "lcd_scanline_mode_timer_defines.svh"

    // ---------------------------------------------------------------
    // Architectural state. Updated only when a request is accepted.
    // ---------------------------------------------------------------
    logic [9:0] r_mode_clock, n_mode_clock;
    logic [7:0] r_line_count, n_line_count;
    logic [7:0] r_status,     n_status;
    logic       r_display_on, n_display_on;
    logic [7:0] r_line_cmp,   n_line_cmp;

    // result register
    logic       r_out_valid;
    logic [7:0] r_line, r_stat_byte;
    logic       r_virq, r_sirq, r_ready, r_frame;
    logic       n_virq, n_sirq, n_ready, n_frame;

    logic       w_accept;
    logic [9:0] w_clk_sum;
    t_lcd_mode  w_cur_mode;
    t_lcd_mode  w_new_mode;
    logic [7:0] w_line_inc;

    // The result register frees up in the same cycle it is drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cur_mode = t_lcd_mode'(r_status[1:0]);
    // advance wraps modulo 1024, like the 10-bit counter it feeds
    assign w_clk_sum  = r_mode_clock + {3'b000, i_cycles};
    assign w_line_inc = r_line_count + 8'd1;

    // ---------------------------------------------------------------
    // Next-state / result logic: at most one mode transition per
    // advance, then the line-compare check on the updated line.
    // ---------------------------------------------------------------
    always_comb begin
        n_mode_clock = r_mode_clock;
        n_line_count = r_line_count;
        n_status     = r_status;
        n_display_on = r_display_on;
        n_line_cmp   = r_line_cmp;
        n_virq       = 1'b0;
        n_sirq       = 1'b0;
        n_ready      = 1'b0;
        n_frame      = 1'b0;
        w_new_mode   = w_cur_mode;

        unique case (i_mode)
            OP_ADVANCE: begin
                if (r_display_on) begin
                    n_mode_clock = w_clk_sum;
                    unique case (w_cur_mode)
                        MD_OAM: begin
                            if (w_clk_sum >= CYC_OAM) begin
                                n_mode_clock = w_clk_sum - CYC_OAM;
                                w_new_mode   = MD_TRANSFER;
                            end
                        end
                        MD_TRANSFER: begin
                            if (w_clk_sum >= CYC_TRANSFER) begin
                                n_mode_clock = w_clk_sum - CYC_TRANSFER;
                                w_new_mode   = MD_HBLANK;
                                n_ready      = 1'b1;
                                n_sirq       = r_status[ST_HBL_EN];
                            end
                        end
                        MD_HBLANK: begin
                            if (w_clk_sum >= CYC_HBLANK) begin
                                n_mode_clock = w_clk_sum - CYC_HBLANK;
                                n_line_count = w_line_inc;
                                if (w_line_inc == LINE_VBLANK) begin
                                    // last visible line done: frame complete
                                    w_new_mode = MD_VBLANK;
                                    n_frame    = 1'b1;
                                    n_virq     = 1'b1;
                                    n_sirq     = r_status[ST_VBL_EN];
                                end else begin
                                    w_new_mode = MD_OAM;
                                    n_sirq     = r_status[ST_OAM_EN];
                                end
                            end
                        end
                        MD_VBLANK: begin
                            if (w_clk_sum >= CYC_VBLANK_LINE) begin
                                n_mode_clock = w_clk_sum - CYC_VBLANK_LINE;
                                n_line_count = w_line_inc;
                                if (w_line_inc == LINE_WRAP) begin
                                    // wrap back to the top of the frame
                                    w_new_mode   = MD_OAM;
                                    n_line_count = '0;
                                    n_sirq       = r_status[ST_OAM_EN];
                                end
                            end
                        end
                    endcase
                    n_status[1:0] = w_new_mode;
                    // coincidence is a level: fires on every matching advance
                    if (r_line_cmp == n_line_count) begin
                        n_status[ST_COINC] = 1'b1;
                        if (r_status[ST_COINC_EN]) begin
                            n_sirq = 1'b1;
                        end
                    end else begin
                        n_status[ST_COINC] = 1'b0;
                    end
                end
            end
            OP_WR_CTRL: begin
                // only the enable bit is kept; switching off parks the timer
                if (r_display_on && !i_value[7]) begin
                    n_line_count  = LINE_OFF;
                    n_mode_clock  = CYC_VBLANK_LINE;
                    n_status[1:0] = MD_VBLANK;
                end
                n_display_on = i_value[7];
            end
            OP_WR_STATUS: begin
                n_status = (i_value & STAT_WMASK) | (r_status & ~STAT_WMASK);
            end
            OP_CLR_LINE: begin
                n_line_count = '0;
            end
            OP_WR_CMP: begin
                n_line_cmp = i_value;
            end
            default: begin
                // unused opcodes leave the state alone
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State and result registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_clock <= CYC_VBLANK_LINE;
            r_line_count <= LINE_OFF;
            r_status     <= {6'd0, MD_VBLANK};
            r_display_on <= 1'b0;
            r_line_cmp   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode_clock <= n_mode_clock;
                r_line_count <= n_line_count;
                r_status     <= n_status;
                r_display_on <= n_display_on;
                r_line_cmp   <= n_line_cmp;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line      <= n_line_count;
            r_stat_byte <= n_status;
            r_virq      <= n_virq;
            r_sirq      <= n_sirq;
            r_ready     <= n_ready;
            r_frame     <= n_frame;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line       = r_line;
    assign o_status     = r_stat_byte;
    assign o_vblank_irq = r_virq;
    assign o_stat_irq   = r_sirq;
    assign o_line_ready = r_ready;
    assign o_frame_done = r_frame;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // frame end always comes with the VBlank interrupt on line 144
    `LSMT_ASSERT_IMP(a_frame_vblank, i_clk, i_rst_n, o_out_valid && o_frame_done, o_vblank_irq && (o_line == LINE_VBLANK) && (o_status[1:0] == MD_VBLANK))
    // end of transfer leaves the controller in HBlank
    `LSMT_ASSERT_IMP(a_ready_hblank, i_clk, i_rst_n, o_out_valid && o_line_ready, o_status[1:0] == MD_HBLANK)
    // while the display is off the mode stays parked in VBlank
    `LSMT_ASSERT_IMP(a_off_vblank, i_clk, i_rst_n, !r_display_on, t_lcd_mode'(r_status[1:0]) == MD_VBLANK)
    // a request taken with the display off cannot raise any flag
    `LSMT_ASSERT_NXT(a_off_quiet, i_clk, i_rst_n, w_accept && !r_display_on, !(o_vblank_irq || o_stat_irq || o_line_ready || o_frame_done))

endmodule
